// ===== src/sfce_pkg.sv =====
// package: shared types, register indexes and reset values for the sbus frame extractor
`timescale 1ns / 1ps

package sfce_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned CHAN_W   = 11;
    localparam int unsigned PULSE_W  = 14;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h00;
    localparam logic [LEN_W-1:0]  FRAME_LEN_RST  = 7'd25;
    localparam logic [POS_W-1:0]  CSUM_POS_RST   = 6'd23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 3'd0,
        CFG_END_BYTE   = 3'd1,
        CFG_FRAME_LEN  = 3'd2,
        CFG_CSUM_POS   = 3'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID    = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_END_ERR  = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [POS_W-1:0]  checksum_position;
    } t_cfg;

endpackage

// ===== src/sfce_cfg_regs.sv =====
// configuration register file for the frame extractor
`timescale 1ns / 1ps

module sfce_cfg_regs
    import sfce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            // unknown indexes are dropped
            unique case (i_cfg_index)
                CFG_START_BYTE: n_cfg.start_byte        = i_cfg_data;
                CFG_END_BYTE:   n_cfg.end_byte          = i_cfg_data;
                CFG_FRAME_LEN:  n_cfg.frame_length      = i_cfg_data[LEN_W-1:0];
                CFG_CSUM_POS:   n_cfg.checksum_position = i_cfg_data[POS_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte        <= START_BYTE_RST;
            r_cfg.end_byte          <= END_BYTE_RST;
            r_cfg.frame_length      <= FRAME_LEN_RST;
            r_cfg.checksum_position <= CSUM_POS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sfce_core.sv =====
// frame tracking state, checksum, channel extraction and result register
`timescale 1ns / 1ps

module sfce_core
    import sfce_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_item_valid,
    input  logic [BYTE_W-1:0]   i_item_byte,
    output logic                o_item_take,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_frame_status,
    output logic [CHAN_W-1:0]   o_channel_value,
    output logic [PULSE_W-1:0]  o_pulse_eighth_us
);

    logic              r_in_frame;
    logic [LEN_W-1:0]  r_byte_count;
    logic [BYTE_W-1:0] r_running_sum;
    logic [BYTE_W-1:0] r_received_check;
    logic [BYTE_W-1:0] r_chan_low;
    logic [2:0]        r_chan_high;

    logic              n_in_frame;
    logic [LEN_W-1:0]  n_byte_count;
    logic [BYTE_W-1:0] n_running_sum;
    logic [BYTE_W-1:0] n_received_check;
    logic [BYTE_W-1:0] n_chan_low;
    logic [2:0]        n_chan_high;

    logic                r_out_valid;
    t_status             r_status;
    logic [CHAN_W-1:0]   r_chan;
    logic [PULSE_W-1:0]  r_pulse;

    logic              w_start;
    logic              w_absorb;
    logic              w_done;
    logic              w_out_free;
    logic [LEN_W-1:0]  w_idx;
    logic [LEN_W-1:0]  w_count_inc;
    logic [BYTE_W-1:0] w_sum_base;
    logic [BYTE_W-1:0] w_check_base;
    logic [BYTE_W-1:0] w_low_base;
    logic [2:0]        w_high_base;
    logic [CHAN_W-1:0] w_chan;
    logic [PULSE_W-1:0] w_pulse;
    t_status           w_status;

    assign w_start     = !r_in_frame && (i_item_byte == i_cfg.start_byte);
    assign w_absorb    = r_in_frame || w_start;
    assign w_idx       = r_in_frame ? r_byte_count : '0;
    assign w_count_inc = r_byte_count + LEN_W'(1);

    // start byte clears the accumulated frame state before index 0 is absorbed
    assign w_sum_base   = w_start ? '0 : r_running_sum;
    assign w_check_base = w_start ? '0 : r_received_check;
    assign w_low_base   = w_start ? '0 : r_chan_low;
    assign w_high_base  = w_start ? '0 : r_chan_high;

    always_comb begin
        n_running_sum    = w_sum_base;
        n_received_check = w_check_base;
        n_chan_low       = w_low_base;
        n_chan_high      = w_high_base;
        if (w_absorb) begin
            if (w_idx < {1'b0, i_cfg.checksum_position}) begin
                n_running_sum = w_sum_base + i_item_byte;
            end else if (w_idx == {1'b0, i_cfg.checksum_position}) begin
                n_received_check = i_item_byte;
            end
            if (w_idx == LEN_W'(1)) begin
                n_chan_low = i_item_byte;
            end else if (w_idx == LEN_W'(2)) begin
                n_chan_high = i_item_byte[2:0];
            end
        end
    end

    assign w_done = r_in_frame && (w_count_inc >= i_cfg.frame_length);

    assign w_chan  = {n_chan_high, n_chan_low};
    // times five as shift and add
    assign w_pulse = {1'b0, w_chan, 2'b00} + {3'b000, w_chan};

    always_comb begin
        priority if (i_item_byte != i_cfg.end_byte) begin
            w_status = ST_END_ERR;
        end else if (n_running_sum != n_received_check) begin
            w_status = ST_CSUM_ERR;
        end else begin
            w_status = ST_VALID;
        end
    end

    // an item that closes a frame needs the result slot to be free
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_item_take = i_item_valid && (!w_done || w_out_free);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        if (w_done) begin
            n_in_frame   = 1'b0;
            n_byte_count = '0;
        end else if (w_start) begin
            n_in_frame   = 1'b1;
            n_byte_count = LEN_W'(1);
        end else if (r_in_frame) begin
            n_byte_count = w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame       <= 1'b0;
            r_byte_count     <= '0;
            r_running_sum    <= '0;
            r_received_check <= '0;
            r_chan_low       <= '0;
            r_chan_high      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (o_item_take) begin
                r_in_frame       <= n_in_frame;
                r_byte_count     <= n_byte_count;
                r_running_sum    <= n_running_sum;
                r_received_check <= n_received_check;
                r_chan_low       <= n_chan_low;
                r_chan_high      <= n_chan_high;
            end
            if (o_item_take && w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && w_done) begin
            r_status <= w_status;
            r_chan   <= w_chan;
            r_pulse  <= w_pulse;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_status    = r_status;
    assign o_channel_value   = r_chan;
    assign o_pulse_eighth_us = r_pulse;

endmodule

// ===== src/sbus_frame_channel_extractor.sv =====
// top level of the sbus frame channel extractor
//
// Input channel: one received serial byte per beat on i_rx_byte, with
// i_in_valid / o_in_stall. Output channel: one result beat per completed
// frame carrying o_frame_status, o_channel_value and o_pulse_eighth_us,
// with o_out_valid / i_out_stall. Configuration: i_cfg_valid / o_cfg_ready
// with i_cfg_index and i_cfg_data; o_cfg_ready is always high and unknown
// indexes are ignored. Write configuration only while no frame is open.
// A byte is first held in an input register, then the frame logic updates
// its running sum, checksum latch and channel bytes and loads the result
// register on the closing byte. Throughput is one byte per cycle while
// o_in_stall is low; results leave from the result register.
// While the receiver stalls the result is held; further bytes still flow
// unless one of them closes another frame, which then waits in the input
// register and raises o_in_stall. Synchronous reset (i_rst_n low) returns
// the block to idle, drops held bytes and results and restores the
// register defaults (start 0x0f, end 0x00, length 25, checksum at 23).
`timescale 1ns / 1ps

module sbus_frame_channel_extractor
    import sfce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_frame_status,
    output logic [CHAN_W-1:0]    o_channel_value,
    output logic [PULSE_W-1:0]   o_pulse_eighth_us,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_take;

    assign o_cfg_ready = 1'b1;

    sfce_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register, refilled whenever the held beat moves on
    assign o_in_stall = r_in_valid && !w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfce_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_item_valid      (r_in_valid),
        .i_item_byte       (r_in_byte),
        .o_item_take       (w_take),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_status    (o_frame_status),
        .o_channel_value   (o_channel_value),
        .o_pulse_eighth_us (o_pulse_eighth_us)
    );

endmodule

// ===== src/sfce_checker.sv =====
// port-level checks for the frame extractor, bound to the top level
`timescale 1ns / 1ps

module sfce_checker
    import sfce_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [STATUS_W-1:0]  o_frame_status,
    input logic [CHAN_W-1:0]    o_channel_value,
    input logic [PULSE_W-1:0]   o_pulse_eighth_us
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_status)
            && $stable(o_channel_value) && $stable(o_pulse_eighth_us))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_status == ST_VALID || o_frame_status == ST_CSUM_ERR
            || o_frame_status == ST_END_ERR))
        else $error("undefined frame status");

    // pulse width must be five times the channel
    a_pulse_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pulse_eighth_us == ({3'b000, o_channel_value} * PULSE_W'(5)))
        else $error("pulse width does not match channel");

endmodule

bind sbus_frame_channel_extractor sfce_checker u_sfce_checker (.*);

// ===== tb/sbus_frame_channel_extractor_tb.sv =====
// testbench: sbus frame channel extractor against an in-bench frame predictor
`timescale 1ns / 1ps

module sbus_frame_channel_extractor_tb;
    import sfce_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned PULSE_FACTOR  = 5;
    localparam int unsigned DIR_ROWS      = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        t_status             status;
        logic [CHAN_W-1:0]   chan;
        logic [PULSE_W-1:0]  pulse;
    } frame_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        frame_result_t     res;
    } dir_row_t;

    // short frames: length 5, checksum at 3, start 0x0f, end 0x00
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'hFF, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h07, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h15, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h00, 1'b1, '{ST_VALID, 11'd2047, 14'd10235}},
        // idle byte that is not the start byte
        '{8'hAA, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h00, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'hF8, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h00, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h00, 1'b1, '{ST_CSUM_ERR, 11'd0, 14'd0}},
        // bad end byte wins over a bad checksum
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h34, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h02, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h12, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'hFF, 1'b1, '{ST_END_ERR, 11'd564, 14'd2820}},
        // start byte value inside a frame is plain data
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h0F, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h2D, 1'b0, '{ST_VALID, 11'd0, 14'd0}},
        '{8'h00, 1'b0, '{ST_VALID, 11'd0, 14'd0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_frame_status;
    logic [CHAN_W-1:0]    o_channel_value;
    logic [PULSE_W-1:0]   o_pulse_eighth_us;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data = '0;

    sbus_frame_channel_extractor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_status    (o_frame_status),
        .o_channel_value   (o_channel_value),
        .o_pulse_eighth_us (o_pulse_eighth_us),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers and frame state
    t_cfg              reg_cfg = '{START_BYTE_RST, END_BYTE_RST, FRAME_LEN_RST, CSUM_POS_RST};
    logic              rx_in_frame = 1'b0;
    logic [LEN_W-1:0]  rx_pos = '0;
    logic [BYTE_W-1:0] rx_sum = '0;
    logic [BYTE_W-1:0] rx_check = '0;
    logic [BYTE_W-1:0] rx_chan_lo = '0;
    logic [2:0]        rx_chan_hi = '0;

    frame_result_t pending_frames [$];
    int unsigned   frame_bytes_taken = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   hold_asks = 0;
    int unsigned   hold_seen = 0;
    int unsigned   hold_left = 0;

    function automatic void take_frame_byte(input logic [BYTE_W-1:0] b,
                                            input logic [LEN_W-1:0] idx);
        if (idx < {1'b0, reg_cfg.checksum_position})
            rx_sum = rx_sum + b;
        else if (idx == {1'b0, reg_cfg.checksum_position})
            rx_check = b;
        if (idx == LEN_W'(1))
            rx_chan_lo = b;
        else if (idx == LEN_W'(2))
            rx_chan_hi = b[2:0];
    endfunction

    task automatic predict_frame_byte(input logic [BYTE_W-1:0] b, output bit closed,
                                      output frame_result_t res);
        logic [CHAN_W-1:0] chan;
        closed = 1'b0;
        res = '0;
        if (!rx_in_frame) begin
            if (b == reg_cfg.start_byte) begin
                rx_in_frame = 1'b1;
                rx_sum = '0;
                rx_check = '0;
                rx_chan_lo = '0;
                rx_chan_hi = '0;
                take_frame_byte(b, '0);
                rx_pos = LEN_W'(1);
                frame_bytes_taken++;
            end
        end else begin
            frame_bytes_taken++;
            take_frame_byte(b, rx_pos);
            rx_pos = rx_pos + 1'b1;
            if (rx_pos >= reg_cfg.frame_length) begin
                chan = {rx_chan_hi, rx_chan_lo};
                if (b != reg_cfg.end_byte)
                    res.status = ST_END_ERR;
                else if (rx_sum != rx_check)
                    res.status = ST_CSUM_ERR;
                else
                    res.status = ST_VALID;
                res.chan = chan;
                res.pulse = PULSE_W'(chan) * PULSE_W'(PULSE_FACTOR);
                rx_in_frame = 1'b0;
                rx_pos = '0;
                closed = 1'b1;
            end
        end
    endtask

    // a typed expectation replaces the predicted one for that beat
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input frame_result_t typed_res);
        frame_result_t res;
        bit            closed;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_byte(b, closed, res);
        if (closed)
            pending_frames.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START_BYTE: reg_cfg.start_byte = data;
            CFG_END_BYTE:   reg_cfg.end_byte = data;
            CFG_FRAME_LEN:  reg_cfg.frame_length = data[LEN_W-1:0];
            CFG_CSUM_POS:   reg_cfg.checksum_position = data[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] eb,
                             input logic [LEN_W-1:0] len, input logic [POS_W-1:0] pos,
                             input bit spare);
        write_reg(CFG_START_BYTE, sb);
        write_reg(CFG_END_BYTE, eb);
        write_reg(CFG_FRAME_LEN, BYTE_W'(len));
        write_reg(CFG_CSUM_POS, BYTE_W'(pos));
        if (spare)
            write_reg(CFG_IDX_SPARE, 8'h55);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for all results, then let bytes that close nothing drain through
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_frame();
        logic [BYTE_W-1:0] fb [0:127];
        logic [BYTE_W-1:0] sum;
        int                n;
        int                kind;
        int                cut;
        int                pos;
        n = (reg_cfg.frame_length <= 2) ? 2 : int'(reg_cfg.frame_length);
        pos = int'(reg_cfg.checksum_position);
        kind = $urandom_range(99);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
        fb[0] = reg_cfg.start_byte;
        for (int i = 1; i < n; i++)
            fb[i] = 8'($urandom);
        sum = '0;
        for (int i = 0; i < n && i < pos; i++)
            sum = sum + fb[i];
        // kinds: good, bad checksum, bad end byte, cut short
        if (pos >= 1 && pos < n)
            fb[pos] = (kind >= 70 && kind < 80) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        fb[n-1] = (kind >= 80 && kind < 90) ?
                  (reg_cfg.end_byte ^ 8'($urandom_range(1, 255))) : reg_cfg.end_byte;
        cut = (kind >= 90) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < cut; i++)
            send_byte(fb[i], 1'b0, '0);
    endtask

    task automatic random_traffic(input int unsigned goal);
        int unsigned target;
        target = frame_bytes_taken + goal;
        while (frame_bytes_taken < target)
            send_random_frame();
        while (rx_in_frame)
            send_byte(8'($urandom), 1'b0, '0);
        settle();
    endtask

    // receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        frame_result_t want;
        frame_result_t seen;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            seen.status = t_status'(o_frame_status);
            seen.chan = o_channel_value;
            seen.pulse = o_pulse_eighth_us;
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected:", $realtime,
                             " status %0d chan %0d pulse %0d",
                             o_frame_status, seen.chan, seen.pulse);
            end else begin
                want = pending_frames.pop_front();
                if (o_frame_status !== want.status || seen.chan !== want.chan ||
                    seen.pulse !== want.pulse) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected status %0d chan %0d pulse %0d,",
                                 $realtime, want.status, want.chan, want.pulse,
                                 " got status %0d chan %0d pulse %0d",
                                 o_frame_status, seen.chan, seen.pulse);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sbus_frame_channel_extractor_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 68;
        random_traffic(200);

        apply_cfg(8'h0F, 8'h00, 7'd5, 6'd3, 1'b0);
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(DIR_TABLE[r].rx, DIR_TABLE[r].typed, DIR_TABLE[r].res);
        settle();

        // checksum byte doubles as the end byte; long hold-off fills the block
        apply_cfg(8'h00, 8'hFF, 7'd4, 6'd3, 1'b0);
        hold_asks++;
        random_traffic(200);

        send_idle_pct = 68;
        recv_idle_pct = 11;
        apply_cfg(8'hFF, 8'h00, 7'd64, 6'd62, 1'b0);
        random_traffic(200);
        // checksum position beyond the frame
        apply_cfg(8'hA5, 8'h5A, 7'd10, 6'd63, 1'b1);
        random_traffic(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // short frames, channel high bits never reached
        apply_cfg(8'h3C, 8'hC3, 7'd2, 6'd5, 1'b0);
        random_traffic(150);
        apply_cfg(8'h80, 8'h7F, 7'd0, 6'd0, 1'b0);
        random_traffic(60);
        apply_cfg(8'h55, 8'hAA, 7'd127, 6'd63, 1'b0);
        random_traffic(200);

        if (mismatch_count == 0)
            $display("sbus_frame_channel_extractor_tb: PASS");
        else
            $display("sbus_frame_channel_extractor_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sfce_pkg.sv
src/sfce_cfg_regs.sv
src/sfce_core.sv
src/sbus_frame_channel_extractor.sv
src/sfce_checker.sv
tb/sbus_frame_channel_extractor_tb.sv
